[sv/syntax_class_lexer_core_assert.svh]
// ----------------------------------------------------------------------------
// syntax class lexer assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SYNTAX_CLASS_LEXER_CORE_ASSERT_SVH
`define SYNTAX_CLASS_LEXER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SCL_ASSERT_NOW(lbl, ante, cons, msg)
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/scl_pkg.sv]
// ----------------------------------------------------------------------------
// syntax class lexer package
// class codes, lexer state type and byte classification helpers
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

  localparam int unsigned ClassW = 3;

  localparam logic [ClassW-1:0] CLS_DEFAULT = 3'd0;
  localparam logic [ClassW-1:0] CLS_BLOCK   = 3'd1;
  localparam logic [ClassW-1:0] CLS_LINE    = 3'd2;
  localparam logic [ClassW-1:0] CLS_DQUOTE  = 3'd3;
  localparam logic [ClassW-1:0] CLS_SQUOTE  = 3'd4;
  localparam logic [ClassW-1:0] CLS_DIGIT   = 3'd5;
  localparam logic [ClassW-1:0] CLS_SYMBOL  = 3'd6;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [ClassW-1:0] shown_class;
    logic [ClassW-1:0] pending_class;
    logic              skip_next;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    shown_class:   CLS_DEFAULT,
    pending_class: CLS_DEFAULT,
    skip_next:     1'b0
  };

  // punctuation set, plus both bytes of the utf-8 pound sign
  function automatic logic in_punct_set(input logic [7:0] ch);
    logic hit;
    hit = ch inside {8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h21, 8'h27,
                     8'hC2, 8'hA3, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h2D,
                     8'h2B, 8'h3D, 8'h3A, 8'h3B, 8'h40, 8'h7E, 8'h23, 8'h3C,
                     8'h3E, 8'h2C, 8'h2E, 8'h3F, 8'h2F, 8'h5C, 8'h7C};
    return hit;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    logic hit;
    hit = ch inside {[CH_ZERO:CH_NINE]};
    return hit;
  endfunction

endpackage

`default_nettype wire

[sv/scl_classify.sv]
// ----------------------------------------------------------------------------
// syntax class lexer step logic
// combinational class decision and next lexer state for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module scl_classify import scl_pkg::*; (
  input  var lex_state_t        state_i,
  input  wire logic [7:0]        current_char_i,
  input  wire logic [7:0]        lookahead_char_i,
  input  wire logic              restart_i,
  output var lex_state_t        state_o,
  output var logic [ClassW-1:0] char_class_o
);

  lex_state_t        cur;
  logic [ClassW-1:0] st;

  always_comb begin
    cur          = restart_i ? LEX_RESET : state_i;
    st           = cur.pending_class;
    state_o      = cur;
    char_class_o = cur.shown_class;

    if (cur.skip_next) begin
      // byte is passed over, repeats the last shown class
      state_o.skip_next = 1'b0;
      char_class_o      = cur.shown_class;
    end else begin
      state_o.shown_class   = st;
      state_o.pending_class = st;
      state_o.skip_next     = 1'b0;
      char_class_o          = st;

      if (st == CLS_DEFAULT && current_char_i == CH_SLASH && lookahead_char_i == CH_STAR) begin
        state_o.skip_next     = 1'b1;
        state_o.shown_class   = CLS_BLOCK;
        state_o.pending_class = CLS_BLOCK;
        char_class_o          = CLS_BLOCK;
      end else if (st == CLS_BLOCK && current_char_i == CH_STAR &&
                   lookahead_char_i == CH_SLASH) begin
        state_o.skip_next     = 1'b1;
        state_o.pending_class = CLS_DEFAULT;
        char_class_o          = CLS_BLOCK;
      end else if (st == CLS_DEFAULT && current_char_i == CH_SLASH &&
                   lookahead_char_i == CH_SLASH) begin
        state_o.skip_next     = 1'b1;
        state_o.shown_class   = CLS_LINE;
        state_o.pending_class = CLS_LINE;
        char_class_o          = CLS_LINE;
      end else if (st == CLS_LINE && current_char_i == CH_NL) begin
        state_o.pending_class = CLS_DEFAULT;
        char_class_o          = CLS_DEFAULT;
      end else if (st == CLS_DEFAULT && current_char_i == CH_DQUOTE) begin
        state_o.pending_class = CLS_DQUOTE;
        char_class_o          = CLS_DQUOTE;
      end else if ((st == CLS_DQUOTE || st == CLS_SQUOTE) && current_char_i == CH_BSLASH) begin
        state_o.skip_next = 1'b1;
        char_class_o      = st;
      end else if (st == CLS_DQUOTE && current_char_i == CH_DQUOTE) begin
        state_o.pending_class = CLS_DEFAULT;
        char_class_o          = CLS_DQUOTE;
      end else if (st == CLS_DEFAULT && current_char_i == CH_SQUOTE) begin
        state_o.pending_class = CLS_SQUOTE;
        char_class_o          = CLS_SQUOTE;
      end else if (st == CLS_SQUOTE && current_char_i == CH_SQUOTE) begin
        state_o.pending_class = CLS_DEFAULT;
        char_class_o          = CLS_SQUOTE;
      end else if (st != CLS_DEFAULT) begin
        char_class_o = st;
      end else if (is_digit(current_char_i)) begin
        state_o.shown_class = CLS_DIGIT;
        char_class_o        = CLS_DIGIT;
      end else if (in_punct_set(current_char_i)) begin
        state_o.shown_class = CLS_SYMBOL;
        char_class_o        = CLS_SYMBOL;
      end else begin
        char_class_o = CLS_DEFAULT;
      end
    end
  end

endmodule

`default_nettype wire

[sv/syntax_class_lexer_core.sv]
// ----------------------------------------------------------------------------
// syntax class lexer core
// per-byte highlight classifier for c-style comments, strings and tokens
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one text byte per beat with the byte that follows
//   it as lookahead and a restart flag that clears the lexer before the byte
//   output channel returns one 3-bit highlight class per input beat, in order
//   both channels use valid/stall; a beat moves when valid is high and stall
//   is low at the rising edge
//   a byte taken into the input register has its class written to the result
//   register when it steps, which it does once the output side is free
//   throughput: one byte per cycle while out_stall_i is low, set by the single
//   pass of compare logic between the input register and the result register
//   when the receiver stalls, the result stays put; the input register holds
//   one more byte and in_stall_o rises only once both registers are full
//   reset clears both valid flags and returns the lexer to the default class
//   with no pending skip
// ----------------------------------------------------------------------------
`default_nettype none

`include "syntax_class_lexer_core_assert.svh"

module syntax_class_lexer_core import scl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output var  logic              in_stall_o,
  input  wire logic [7:0]        current_char_i,
  input  wire logic [7:0]        lookahead_char_i,
  input  wire logic              restart_i,
  output var  logic              out_valid_o,
  input  wire logic              out_stall_i,
  output var  logic [ClassW-1:0] char_class_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] cur_char_q;
  logic [7:0] look_char_q;
  logic       restart_q;

  // lexer state, advanced once per byte moved to the output
  lex_state_t state_q;
  lex_state_t state_d;

  // result register
  logic              out_valid_q;
  logic [ClassW-1:0] class_q;
  logic [ClassW-1:0] class_d;

  logic out_free;
  logic step;
  logic in_fire;

  // output register can take a new result when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  scl_classify u_classify (
    .state_i          (state_q),
    .current_char_i   (cur_char_q),
    .lookahead_char_i (look_char_q),
    .restart_i        (restart_q),
    .state_o          (state_d),
    .char_class_o     (class_d)
  );

  // input stage valid: refilled on accept, emptied when its byte steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_char_q  <= current_char_i;
      look_char_q <= lookahead_char_i;
      restart_q   <= restart_i;
    end
  end

  // lexer context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LEX_RESET;
    end else if (step) begin
      state_q <= state_d;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_class_o = class_q;

  // a skipped byte never leaves another skip behind unless it restarts
  `SCL_ASSERT_NEXT(a_skip_single, step && state_q.skip_next && !restart_q,
                   !state_q.skip_next, "skip flag held over two bytes")

  // a byte that steps always lands in the result register
  `SCL_ASSERT_NEXT(a_step_lands, step, out_valid_q, "stepped byte lost before output")

  // input side stalls only when both stages are occupied
  `SCL_ASSERT_NOW(a_stall_full, in_stall_o, in_valid_q && out_valid_q, "stall with a free stage")

  // pending context is never a digit or symbol class
  `SCL_ASSERT_NOW(a_pending_range, out_valid_q, state_q.pending_class <= CLS_SQUOTE,
                  "bad pending class")

endmodule

`default_nettype wire
